// ===== src/dqsb_pkg.sv =====
package dqsb_pkg;

  // Output and bias format codes.
  localparam logic [1:0] FMT_FP32 = 2'd0;
  localparam logic [1:0] FMT_FP16 = 2'd1;
  localparam logic [1:0] FMT_BF16 = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_OUTPUT_FORMAT       = 3'd0;
  localparam logic [2:0] CFG_BIAS_ENABLE         = 3'd1;
  localparam logic [2:0] CFG_SCALAR_WEIGHT_MODE  = 3'd2;
  localparam logic [2:0] CFG_SCALAR_WEIGHT_SCALE = 3'd3;

  // Canonical quiet NaNs.
  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
  localparam logic [15:0] QNAN16 = 16'h7E00;
  localparam logic [15:0] QNANBF = 16'h7FC0;

  // Leading zero count of a 50-bit word; 50 for an all-zero word.
  function automatic logic [5:0] lzc50(input logic [49:0] x);
    logic [5:0] n;
    n = 6'd50;
    for (int i = 0; i < 50; i++) begin
      if (x[i]) n = 6'(49 - i);
    end
    return n;
  endfunction

  function automatic logic is_nan32(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  // Rounds sig * 2^(e - 176) to fp32, nearest even, with subnormals.
  // A nonzero sig has its top bit at bit 49.
  function automatic logic [31:0] round32(input logic s, input logic signed [11:0] e,
                                          input logic [49:0] sig);
    logic [99:0] sh_v;
    logic [11:0] shamt;
    logic [23:0] mant;
    logic        g;
    logic        st;
    logic        up;
    logic [7:0]  ef;
    logic [30:0] mag;
    logic [31:0] res;
    shamt = 12'd0;
    if (e < 12'sd1) begin
      shamt = 12'(12'sd1 - e);
      if (shamt > 12'd51) shamt = 12'd51;
    end
    sh_v = {sig, 50'b0} >> shamt;
    mant = sh_v[99:76];
    g    = sh_v[75];
    st   = |sh_v[74:0];
    up   = g & (st | mant[0]);
    ef   = (e < 12'sd1) ? 8'd0 : e[7:0];
    mag  = {ef, mant[22:0]} + {30'b0, up};
    if (sig == 50'd0) begin
      res = {s, 31'b0};
    end else if (e > 12'sd254) begin
      res = {s, 8'hFF, 23'b0};
    end else begin
      res = {s, mag};
    end
    return res;
  endfunction

  // Exact widening of fp16 to fp32.
  function automatic logic [31:0] h2s(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [5:0]  k;
    logic [9:0]  mn;
    logic [31:0] res;
    ex  = h[14:10];
    man = h[9:0];
    k   = lzc50({man, 40'b0}) + 6'd1;
    mn  = man << k;
    if (ex == 5'd31) begin
      res = {h[15], 8'hFF, man, 13'b0};
    end else if (ex == 5'd0) begin
      if (man == 10'd0) res = {h[15], 31'b0};
      else res = {h[15], 8'(8'd113 - {2'b0, k}), mn, 13'b0};
    end else begin
      res = {h[15], 8'({3'b0, ex} + 8'd112), man, 13'b0};
    end
    return res;
  endfunction

  // Rounds fp32 to fp16, nearest even; fp32 subnormals go to zero.
  function automatic logic [15:0] s2h(input logic [31:0] b);
    logic              sign;
    logic [7:0]        ex;
    logic signed [9:0] e;
    logic [9:0]        shift;
    logic [47:0]       sh_v;
    logic [11:0]       q;
    logic              up;
    logic [15:0]       ebits;
    logic [15:0]       res;
    sign  = b[31];
    ex    = b[30:23];
    e     = $signed({2'b0, ex}) - 10'sd127;
    shift = (e >= -10'sd14) ? 10'd13 : 10'(-10'sd1 - e);
    sh_v  = {1'b1, b[22:0], 24'b0} >> shift;
    up    = sh_v[23] & ((|sh_v[22:0]) | sh_v[24]);
    q     = {1'b0, sh_v[34:24]} + {11'b0, up};
    ebits = {1'b0, 5'(e + 10'sd14), 10'b0};
    if (ex == 8'hFF) begin
      res = (b[22:0] != 23'd0) ? QNAN16 : {sign, 15'h7C00};
    end else if (ex == 8'd0) begin
      res = {sign, 15'b0};
    end else if (e > 10'sd15) begin
      res = {sign, 15'h7C00};
    end else if (shift > 10'd25) begin
      res = {sign, 15'b0};
    end else if (e >= -10'sd14) begin
      res = {sign, 15'b0} | (ebits + {4'b0, q});
    end else begin
      res = {sign, 15'b0} | {4'b0, q};
    end
    return res;
  endfunction

  // Final rounding of the fp32 sum to the output format.
  function automatic logic [31:0] fmt_out(input logic [1:0] fmt, input logic [31:0] f);
    logic [31:0] bsum;
    logic [31:0] res;
    bsum = f + 32'h0000_7FFF + {31'b0, f[16]};
    case (fmt)
      FMT_FP32: res = is_nan32(f) ? QNAN32 : f;
      FMT_FP16: res = {16'b0, s2h(f)};
      default:  res = is_nan32(f) ? {16'b0, QNANBF} : {16'b0, bsum[31:16]};
    endcase
    return res;
  endfunction

  // Bias widened exactly to fp32.
  function automatic logic [31:0] bias_widen(input logic [1:0] fmt, input logic [31:0] bv);
    logic [31:0] res;
    case (fmt)
      FMT_FP32: res = bv;
      FMT_FP16: res = h2s(bv[15:0]);
      default:  res = {bv[15:0], 16'b0};
    endcase
    return res;
  endfunction

endpackage

// ===== src/dqsb_fmul.sv =====
// Three-stage fp32 multiplier: mantissa product, normalize, round.
module dqsb_fmul #(
  parameter int TagW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [31:0]     a,
  input  logic [31:0]     b,
  input  logic [TagW-1:0] tag,
  output logic            out_valid,
  output logic [31:0]     product,
  output logic [TagW-1:0] tag_out
);

  logic [7:0]  ea, eb;
  logic [7:0]  xa, xb;
  logic [23:0] ma, mb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;

  // Stage one registers.
  logic               m1_valid;
  logic [47:0]        m1_p;
  logic signed [11:0] m1_e;
  logic               m1_s, m1_nan, m1_inf;
  logic [TagW-1:0]    m1_tag;
  // Stage two registers.
  logic               m2_valid;
  logic [49:0]        m2_sig;
  logic signed [11:0] m2_e;
  logic               m2_s, m2_nan, m2_inf;
  logic [TagW-1:0]    m2_tag;
  // Stage three registers.
  logic               m3_valid;
  logic [31:0]        m3_f;
  logic [TagW-1:0]    m3_tag;

  logic [5:0] lz;

  // Operand unpacking; subnormals use exponent one without the hidden bit.
  always_comb begin
    ea     = a[30:23];
    eb     = b[30:23];
    xa     = (ea == 8'd0) ? 8'd1 : ea;
    xb     = (eb == 8'd0) ? 8'd1 : eb;
    ma     = {ea != 8'd0, a[22:0]};
    mb     = {eb != 8'd0, b[22:0]};
    nan_a  = (ea == 8'hFF) && (a[22:0] != 23'd0);
    nan_b  = (eb == 8'hFF) && (b[22:0] != 23'd0);
    inf_a  = (ea == 8'hFF) && (a[22:0] == 23'd0);
    inf_b  = (eb == 8'hFF) && (b[22:0] == 23'd0);
    zero_a = (ea == 8'd0) && (a[22:0] == 23'd0);
    zero_b = (eb == 8'd0) && (b[22:0] == 23'd0);
  end

  assign lz = dqsb_pkg::lzc50({m1_p, 2'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= in_valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Product of the raw mantissas and the biased exponent sum.
      m1_p   <= 48'(ma) * 48'(mb);
      m1_e   <= $signed({4'b0, xa}) + $signed({4'b0, xb}) - 12'sd126;
      m1_s   <= a[31] ^ b[31];
      m1_nan <= nan_a | nan_b | (inf_a & zero_b) | (inf_b & zero_a);
      m1_inf <= inf_a | inf_b;
      m1_tag <= tag;
      // Left-align the product.
      m2_sig <= {m1_p, 2'b0} << lz;
      m2_e   <= m1_e - $signed({6'b0, lz});
      m2_s   <= m1_s;
      m2_nan <= m1_nan;
      m2_inf <= m1_inf;
      m2_tag <= m1_tag;
      // Round, or give the special result.
      if (m2_nan) m3_f <= dqsb_pkg::QNAN32;
      else if (m2_inf) m3_f <= {m2_s, 8'hFF, 23'b0};
      else m3_f <= dqsb_pkg::round32(m2_s, m2_e, m2_sig);
      m3_tag <= m2_tag;
    end
  end

  assign out_valid = m3_valid;
  assign product   = m3_f;
  assign tag_out   = m3_tag;

endmodule

// ===== src/dqsb_fadd.sv =====
// Four-stage fp32 adder: order operands, align and add, normalize, round.
// With add_en low the first operand passes unchanged.
module dqsb_fadd (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        add_en,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  output logic [31:0] sum
);

  logic        swap;
  logic [31:0] x, y;
  logic [7:0]  ex_raw, ey_raw, ex, ey;
  logic        nan_x, nan_y, inf_x, inf_y, sub;

  // Stage one registers.
  logic        a1_valid;
  logic [23:0] a1_mx, a1_my;
  logic [7:0]  a1_ex, a1_d;
  logic        a1_s, a1_sub, a1_nan, a1_inf, a1_zs, a1_pass;
  logic [31:0] a1_raw;
  // Stage two registers.
  logic        a2_valid;
  logic [50:0] a2_sum;
  logic [7:0]  a2_ex;
  logic        a2_s, a2_nan, a2_inf, a2_zs, a2_pass;
  logic [31:0] a2_raw;
  // Stage three registers.
  logic               a3_valid;
  logic [49:0]        a3_sig;
  logic signed [11:0] a3_e;
  logic               a3_s, a3_nan, a3_inf, a3_zs, a3_zero, a3_pass;
  logic [31:0]        a3_raw;
  // Stage four registers.
  logic        a4_valid;
  logic [31:0] a4_f;

  logic [7:0]  d_cap;
  logic [99:0] y_sh;
  logic [49:0] xv, yv;
  logic [5:0]  lz;

  // Put the larger magnitude first.
  always_comb begin
    swap   = a[30:0] < b[30:0];
    x      = swap ? b : a;
    y      = swap ? a : b;
    ex_raw = x[30:23];
    ey_raw = y[30:23];
    ex     = (ex_raw == 8'd0) ? 8'd1 : ex_raw;
    ey     = (ey_raw == 8'd0) ? 8'd1 : ey_raw;
    nan_x  = (ex_raw == 8'hFF) && (x[22:0] != 23'd0);
    nan_y  = (ey_raw == 8'hFF) && (y[22:0] != 23'd0);
    inf_x  = (ex_raw == 8'hFF) && (x[22:0] == 23'd0);
    inf_y  = (ey_raw == 8'hFF) && (y[22:0] == 23'd0);
    sub    = x[31] ^ y[31];
  end

  // Alignment of the smaller operand, with a sticky bit for lost bits.
  always_comb begin
    d_cap = (a1_d > 8'd60) ? 8'd60 : a1_d;
    y_sh  = {a1_my, 26'b0, 50'b0} >> d_cap;
    xv    = {a1_mx, 26'b0};
    yv    = y_sh[99:50] | {49'b0, |y_sh[49:0]};
  end

  assign lz = dqsb_pkg::lzc50(a2_sum[49:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      a1_valid <= 1'b0;
      a2_valid <= 1'b0;
      a3_valid <= 1'b0;
      a4_valid <= 1'b0;
    end else if (en) begin
      a1_valid <= in_valid;
      a2_valid <= a1_valid;
      a3_valid <= a2_valid;
      a4_valid <= a3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_mx   <= {ex_raw != 8'd0, x[22:0]};
      a1_my   <= {ey_raw != 8'd0, y[22:0]};
      a1_ex   <= ex;
      a1_d    <= ex - ey;
      a1_s    <= x[31];
      a1_sub  <= sub;
      a1_nan  <= nan_x | nan_y | (inf_x & inf_y & sub);
      a1_inf  <= inf_x | inf_y;
      a1_zs   <= sub ? 1'b0 : x[31];
      a1_pass <= !add_en;
      a1_raw  <= a;

      a2_sum  <= a1_sub ? ({1'b0, xv} - {1'b0, yv}) : ({1'b0, xv} + {1'b0, yv});
      a2_ex   <= a1_ex;
      a2_s    <= a1_s;
      a2_nan  <= a1_nan;
      a2_inf  <= a1_inf;
      a2_zs   <= a1_zs;
      a2_pass <= a1_pass;
      a2_raw  <= a1_raw;

      // Normalize: a carry out moves right by one, else shift left.
      if (a2_sum[50]) begin
        a3_sig <= {a2_sum[50:2], a2_sum[1] | a2_sum[0]};
        a3_e   <= $signed({4'b0, a2_ex}) + 12'sd1;
      end else begin
        a3_sig <= a2_sum[49:0] << lz;
        a3_e   <= $signed({4'b0, a2_ex}) - $signed({6'b0, lz});
      end
      a3_zero <= (a2_sum == 51'd0);
      a3_s    <= a2_s;
      a3_nan  <= a2_nan;
      a3_inf  <= a2_inf;
      a3_zs   <= a2_zs;
      a3_pass <= a2_pass;
      a3_raw  <= a2_raw;

      if (a3_pass) a4_f <= a3_raw;
      else if (a3_nan) a4_f <= dqsb_pkg::QNAN32;
      else if (a3_inf) a4_f <= {a3_s, 8'hFF, 23'b0};
      else if (a3_zero) a4_f <= {a3_zs, 31'b0};
      else a4_f <= dqsb_pkg::round32(a3_s, a3_e, a3_sig);
    end
  end

  assign out_valid = a4_valid;
  assign sum       = a4_f;

endmodule

// ===== src/int32_dequant_scale_bias.sv =====
// Throughput: one request per cycle; the 14-stage pipeline (3 conversion,
// 3 per multiplier, 4 adder, 1 output) advances whenever the output is not stalled.
// Reset: synchronous and active high; clears all valid bits and sets the
// registers to bf16 output, bias off, column scales, and a scalar scale of 1.0.
module int32_dequant_scale_bias (
  input  logic        clk,
  input  logic        rst,
  input  logic        acc_valid,
  output logic        acc_stall,
  input  logic [31:0] accumulator,
  input  logic [31:0] row_scale,
  input  logic [31:0] column_scale,
  input  logic [31:0] bias_value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] result_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [1:0]  output_format;
  logic        bias_enable;
  logic        scalar_weight_mode;
  logic [31:0] scalar_weight_scale;

  logic en;

  // Conversion stages.
  logic               s1_valid, s1_neg;
  logic [31:0]        s1_mag, s1_rs, s1_ws, s1_bias;
  logic               s2_valid, s2_neg;
  logic [49:0]        s2_sig;
  logic signed [11:0] s2_e;
  logic [31:0]        s2_rs, s2_ws, s2_bias;
  logic               s3_valid;
  logic [31:0]        s3_f, s3_rs, s3_ws, s3_bias;

  logic        m1_valid, m2_valid, ad_valid;
  logic [31:0] m1_f, m2_f, ad_f, m2_bias;
  logic [63:0] m1_tag;

  logic        out_valid;
  logic [31:0] out_bits;
  logic [1:0]  out_fmt;

  logic [5:0] lz;

  // Configuration writes; indexes beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_format       <= dqsb_pkg::FMT_BF16;
      bias_enable         <= 1'b0;
      scalar_weight_mode  <= 1'b0;
      scalar_weight_scale <= 32'h3F80_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dqsb_pkg::CFG_OUTPUT_FORMAT:       output_format       <= cfg_data[1:0];
        dqsb_pkg::CFG_BIAS_ENABLE:         bias_enable         <= cfg_data[0];
        dqsb_pkg::CFG_SCALAR_WEIGHT_MODE:  scalar_weight_mode  <= cfg_data[0];
        dqsb_pkg::CFG_SCALAR_WEIGHT_SCALE: scalar_weight_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline holds while a finished result is stalled.
  assign en        = !(out_valid && result_stall);
  assign acc_stall = out_valid && result_stall;

  assign lz = dqsb_pkg::lzc50({s1_mag, 18'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= acc_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= ad_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Magnitude of the accumulator, weight scale choice, bias widening.
      s1_neg  <= accumulator[31];
      s1_mag  <= accumulator[31] ? (32'd0 - accumulator) : accumulator;
      s1_rs   <= row_scale;
      s1_ws   <= scalar_weight_mode ? scalar_weight_scale : column_scale;
      s1_bias <= dqsb_pkg::bias_widen(output_format, bias_value);
      // Left-align the magnitude.
      s2_sig  <= {s1_mag, 18'b0} << lz;
      s2_e    <= 12'sd158 - $signed({6'b0, lz});
      s2_neg  <= s1_neg;
      s2_rs   <= s1_rs;
      s2_ws   <= s1_ws;
      s2_bias <= s1_bias;
      // Round to fp32.
      s3_f    <= dqsb_pkg::round32(s2_neg, s2_e, s2_sig);
      s3_rs   <= s2_rs;
      s3_ws   <= s2_ws;
      s3_bias <= s2_bias;
      // Final format conversion.
      out_bits <= dqsb_pkg::fmt_out(output_format, ad_f);
      out_fmt  <= output_format;
    end
  end

  // Row scale, then weight scale, each rounded.
  dqsb_fmul #(.TagW(64)) u_mul_row (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s3_valid), .a(s3_f), .b(s3_rs), .tag({s3_ws, s3_bias}),
    .out_valid(m1_valid), .product(m1_f), .tag_out(m1_tag)
  );

  dqsb_fmul #(.TagW(32)) u_mul_weight (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(m1_valid), .a(m1_f), .b(m1_tag[63:32]), .tag(m1_tag[31:0]),
    .out_valid(m2_valid), .product(m2_f), .tag_out(m2_bias)
  );

  // Bias addition, bypassed when disabled.
  dqsb_fadd u_add_bias (
    .clk(clk), .rst(rst), .en(en), .add_en(bias_enable),
    .in_valid(m2_valid), .a(m2_f), .b(m2_bias),
    .out_valid(ad_valid), .sum(ad_f)
  );

  assign result_valid = out_valid;
  assign result_bits  = out_bits;

  // A NaN in fp32 output is always the canonical one.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_fmt == dqsb_pkg::FMT_FP32 && dqsb_pkg::is_nan32(out_bits))
      |-> (out_bits == dqsb_pkg::QNAN32))
    else $error("non-canonical fp32 NaN at the output");

  // Half-width formats leave the upper half clear.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_fmt != dqsb_pkg::FMT_FP32) |-> (out_bits[31:16] == 16'd0))
    else $error("upper half set in a 16-bit result");

  // A held result keeps the pipeline frozen, so the adder output holds too.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_stall) |=> ($stable(ad_valid) && $stable(ad_f)))
    else $error("pipeline moved under a stalled result");

endmodule
